@@ rtl/core/fbf_pkg.sv @@
// ----------------------------------------------------------------------------
// fbf_pkg
// Shared types, codes and the control store of the hole allocator.
// ----------------------------------------------------------------------------
package fbf_pkg;

  // table geometry
  localparam int MAX_HOLES = 32;
  localparam int IDX_W     = 5;   // bits of a table index
  localparam int CNT_W     = 6;   // bits of the fill count, holds MAX_HOLES
  localparam int DATA_W    = 32;
  localparam int ENTRY_W   = 2 * DATA_W;  // {start, size}

  // item kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_PASS = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // datapath actions
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_ADD,
    OP_PASS,
    OP_ZERO,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_NOFIT,
    OP_GRANT,
    OP_SHIFT,
    OP_INSERT,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_IN,
    C_KIND_ADD,
    C_KIND_REQ,
    C_KIND_PASS,
    C_SCAN_BUSY,
    C_NO_CAND,
    C_NO_SPLIT,
    C_SHIFT_BUSY,
    C_OUT_BUSY
  } cond_t;

  localparam int STEP_W = 4;

  // step addresses
  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ADD   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_PASS  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SINIT = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SCAN  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SHIFT = 4'd11;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd15;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic kind_add;
    logic kind_req;
    logic kind_pass;
    logic scan_busy;
    logic no_cand;
    logic no_split;
    logic shift_busy;
  } flags_t;

  // one result item
  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] grant_address;
    logic [IDX_W-1:0]  grant_index;
    logic [DATA_W-1:0] leftover;
  } result_t;

  // Control store. The emit step sits at the last address so that
  // falling through wraps back to idle.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      4'd0:    w = '{op: OP_LATCH,     cond: C_NOT_IN,     target: STEP_IDLE};
      4'd1:    w = '{op: OP_NOP,       cond: C_KIND_ADD,   target: STEP_ADD};
      4'd2:    w = '{op: OP_NOP,       cond: C_KIND_REQ,   target: STEP_SINIT};
      4'd3:    w = '{op: OP_NOP,       cond: C_KIND_PASS,  target: STEP_PASS};
      4'd4:    w = '{op: OP_ZERO,      cond: C_ALWAYS,     target: STEP_EMIT};
      4'd5:    w = '{op: OP_ADD,       cond: C_ALWAYS,     target: STEP_EMIT};
      4'd6:    w = '{op: OP_PASS,      cond: C_ALWAYS,     target: STEP_EMIT};
      4'd7:    w = '{op: OP_SCAN_INIT, cond: C_NEVER,      target: STEP_IDLE};
      4'd8:    w = '{op: OP_SCAN,      cond: C_SCAN_BUSY,  target: STEP_SCAN};
      4'd9:    w = '{op: OP_NOFIT,     cond: C_NO_CAND,    target: STEP_EMIT};
      4'd10:   w = '{op: OP_GRANT,     cond: C_NO_SPLIT,   target: STEP_EMIT};
      4'd11:   w = '{op: OP_SHIFT,     cond: C_SHIFT_BUSY, target: STEP_SHIFT};
      4'd12:   w = '{op: OP_INSERT,    cond: C_ALWAYS,     target: STEP_EMIT};
      4'd15:   w = '{op: OP_EMIT,      cond: C_OUT_BUSY,   target: STEP_EMIT};
      default: w = '{op: OP_NOP,       cond: C_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/fbf_ram.sv @@
// ----------------------------------------------------------------------------
// fbf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/fbf_seq.sv @@
// ----------------------------------------------------------------------------
// fbf_seq
// Microcode sequencer: step counter, control store fetch, conditional jumps.
// ----------------------------------------------------------------------------
module fbf_seq (
  input  logic            clk,
  input  logic            rst,
  input  fbf_pkg::flags_t flags,
  input  logic            in_valid,
  input  logic            out_busy,
  output fbf_pkg::ucode_t cw
);

  logic [fbf_pkg::STEP_W-1:0] upc;
  logic [fbf_pkg::STEP_W-1:0] upc_next;
  logic                       jump;

  assign cw = fbf_pkg::ucode_rom(upc);

  // condition select
  always_comb begin
    unique case (cw.cond)
      fbf_pkg::C_NEVER:      jump = 1'b0;
      fbf_pkg::C_ALWAYS:     jump = 1'b1;
      fbf_pkg::C_NOT_IN:     jump = !in_valid;
      fbf_pkg::C_KIND_ADD:   jump = flags.kind_add;
      fbf_pkg::C_KIND_REQ:   jump = flags.kind_req;
      fbf_pkg::C_KIND_PASS:  jump = flags.kind_pass;
      fbf_pkg::C_SCAN_BUSY:  jump = flags.scan_busy;
      fbf_pkg::C_NO_CAND:    jump = flags.no_cand;
      fbf_pkg::C_NO_SPLIT:   jump = flags.no_split;
      fbf_pkg::C_SHIFT_BUSY: jump = flags.shift_busy;
      fbf_pkg::C_OUT_BUSY:   jump = out_busy;
      default:               jump = 1'b1;
    endcase
    upc_next = jump ? cw.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= fbf_pkg::STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ rtl/core/fbf_dp.sv @@
// ----------------------------------------------------------------------------
// fbf_dp
// Datapath: hole table RAM, taken marks, fill count, scan and shift logic.
// ----------------------------------------------------------------------------
module fbf_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  fbf_pkg::ucode_t              cw,
  input  logic                         fit_mode,
  input  logic                         in_xfer,
  input  logic [1:0]                   in_kind,
  input  logic [fbf_pkg::DATA_W-1:0]   in_start,
  input  logic [fbf_pkg::DATA_W-1:0]   in_amount,
  output fbf_pkg::flags_t              flags,
  output fbf_pkg::result_t             res
);

  localparam int AW = fbf_pkg::IDX_W;
  localparam int CW = fbf_pkg::CNT_W;
  localparam int DW = fbf_pkg::DATA_W;
  localparam int NH = fbf_pkg::MAX_HOLES;
  localparam logic [CW-1:0] FULL_CNT = CW'(NH);

  // latched item
  logic [1:0]    kind_q;
  logic [DW-1:0] start_q;
  logic [DW-1:0] amt_q;

  // table control
  logic [CW-1:0] cnt;
  logic [CW-1:0] ptr;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [NH-1:0] taken;

  // best candidate so far
  logic          cand_vld;
  logic [AW-1:0] cand_idx;
  logic [DW-1:0] cand_len;
  logic [DW-1:0] cand_addr;

  // RAM ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [fbf_pkg::ENTRY_W-1:0] ram_wdata;
  logic [fbf_pkg::ENTRY_W-1:0] ram_rdata;
  logic [DW-1:0]               rd_addr;
  logic [DW-1:0]               rd_len;

  fbf_ram #(
    .WIDTH (fbf_pkg::ENTRY_W),
    .DEPTH (NH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_addr = ram_rdata[fbf_pkg::ENTRY_W-1:DW];
  assign rd_len  = ram_rdata[DW-1:0];

  // scan, split and shift decisions
  logic          scan_issue;
  logic          fits;
  logic          better;
  logic          split_ok;
  logic          shift_issue;
  logic [DW-1:0] rest;
  logic [NH-1:0] taken_up;
  logic [NH-1:0] move_mask;
  logic [NH-1:0] taken_split;
  logic [AW-1:0] ins_idx;

  assign scan_issue  = ptr < cnt;
  assign fits        = !taken[rd_idx] && (rd_len >= amt_q);
  assign better      = !cand_vld || (fit_mode && (rd_len < cand_len));
  assign split_ok    = (cand_len > amt_q) && (cnt < FULL_CNT);
  assign rest        = cand_len - amt_q;
  assign shift_issue = ptr > {1'b0, cand_idx};
  assign taken_up    = {taken[NH-2:0], 1'b0};
  assign ins_idx     = cand_idx + 1'b1;

  // entries that move up one place on a split
  always_comb begin
    for (int k = 0; k < NH; k++) begin
      move_mask[k] = (CW'(k) > ({1'b0, cand_idx} + 1'b1)) && (CW'(k) <= cnt);
    end
  end

  // taken marks after a split
  always_comb begin
    taken_split           = (taken & ~move_mask) | (taken_up & move_mask);
    taken_split[cand_idx] = 1'b1;
    taken_split[ins_idx]  = 1'b0;
  end

  // flags for the sequencer
  always_comb begin
    flags.kind_add   = kind_q == fbf_pkg::KIND_ADD;
    flags.kind_req   = kind_q == fbf_pkg::KIND_REQ;
    flags.kind_pass  = kind_q == fbf_pkg::KIND_PASS;
    flags.scan_busy  = (scan_issue || rd_vld) && !(!fit_mode && cand_vld);
    flags.no_cand    = !cand_vld;
    flags.no_split   = !split_ok;
    flags.shift_busy = shift_issue || rd_vld;
  end

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = {start_q, amt_q};
    unique case (cw.op)
      fbf_pkg::OP_ADD: begin
        ram_we = cnt < FULL_CNT;
      end
      fbf_pkg::OP_GRANT: begin
        ram_we    = split_ok;
        ram_waddr = cand_idx;
        ram_wdata = {cand_addr, amt_q};
      end
      fbf_pkg::OP_SHIFT: begin
        ram_we    = rd_vld;
        ram_waddr = rd_idx + 1'b1;
        ram_wdata = ram_rdata;
      end
      fbf_pkg::OP_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = ins_idx;
        ram_wdata = {cand_addr + amt_q, res.leftover};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      taken    <= '0;
      rd_vld   <= 1'b0;
      cand_vld <= 1'b0;
      ptr      <= '0;
    end else begin
      unique case (cw.op)
        fbf_pkg::OP_ADD: begin
          if (cnt < FULL_CNT) begin
            taken[cnt[AW-1:0]] <= 1'b0;
            cnt                <= cnt + 1'b1;
          end
        end
        fbf_pkg::OP_PASS: begin
          taken <= '0;
        end
        fbf_pkg::OP_SCAN_INIT: begin
          ptr      <= '0;
          rd_vld   <= 1'b0;
          cand_vld <= 1'b0;
        end
        fbf_pkg::OP_SCAN: begin
          rd_vld <= scan_issue;
          if (scan_issue) begin
            ptr <= ptr + 1'b1;
          end
          if (rd_vld && fits && better) begin
            cand_vld <= 1'b1;
          end
        end
        fbf_pkg::OP_GRANT: begin
          ptr    <= cnt - 1'b1;
          rd_vld <= 1'b0;
          if (split_ok) begin
            taken <= taken_split;
          end else begin
            taken[cand_idx] <= 1'b1;
          end
        end
        fbf_pkg::OP_SHIFT: begin
          rd_vld <= shift_issue;
          if (shift_issue) begin
            ptr <= ptr - 1'b1;
          end
        end
        fbf_pkg::OP_INSERT: begin
          cnt <= cnt + 1'b1;
        end
        default: begin
          rd_vld <= rd_vld;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cw.op == fbf_pkg::OP_LATCH && in_xfer) begin
      kind_q  <= in_kind;
      start_q <= in_start;
      amt_q   <= in_amount;
    end
    if (cw.op == fbf_pkg::OP_SCAN || cw.op == fbf_pkg::OP_SHIFT) begin
      rd_idx <= ptr[AW-1:0];
    end
    if (cw.op == fbf_pkg::OP_SCAN && rd_vld && fits && better) begin
      cand_idx  <= rd_idx;
      cand_len  <= rd_len;
      cand_addr <= rd_addr;
    end
    unique case (cw.op)
      fbf_pkg::OP_ADD: begin
        if (cnt < FULL_CNT) begin
          res <= '{status: fbf_pkg::ST_DONE, grant_address: '0,
                   grant_index: cnt[AW-1:0], leftover: '0};
        end else begin
          res <= '{status: fbf_pkg::ST_FULL, grant_address: '0,
                   grant_index: '0, leftover: '0};
        end
      end
      fbf_pkg::OP_PASS, fbf_pkg::OP_ZERO: begin
        res <= '0;
      end
      fbf_pkg::OP_NOFIT: begin
        res <= '{status: fbf_pkg::ST_NOFIT, grant_address: '0,
                 grant_index: '0, leftover: '0};
      end
      fbf_pkg::OP_GRANT: begin
        res <= '{status: fbf_pkg::ST_DONE, grant_address: cand_addr,
                 grant_index: cand_idx, leftover: split_ok ? rest : '0};
      end
      default: begin
        res <= res;
      end
    endcase
  end

endmodule

@@ rtl/core/first_best_fit_hole_allocator.sv @@
// ----------------------------------------------------------------------------
// first_best_fit_hole_allocator
// Hole table allocator with first-fit and best-fit selection.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ stream (tuser = kind, tdata = start, amount);
// each gives exactly one result on the m_ stream (tuser = status, tdata =
// grant address, grant index, leftover). fit_mode is written on the cfg
// channel; the user must write it only while the block is idle, a rule left
// unenforced by the block itself. cfg_ready is always high. Control is a
// microprogram; s_tready is high only at its idle step, so one item is in
// work at a time; the next transfer can be taken in the cycle m_tvalid rises.
// A request's scan reads all holes in best fit, and the holes up to the chosen
// one in first fit, one table RAM read per cycle. A split then shifts the
// entries above the chosen one up one place, at one RAM read and write per
// cycle. The worst request is a best-fit split of entry 0 in a 31-entry
// table.
// The result sits in an output register; the next item is taken while it
// waits. When the receiver stalls, the program holds at its emit step and
// accepts no further item until the register is free.
// Reset clears the hole count, taken marks, fit_mode and all valid flags;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_best_fit_hole_allocator (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] hole_start, [63:32] amount
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] grant_address, [36:32] grant_index,
                                 // [68:37] leftover, [71:69] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // fit_mode
);

  fbf_pkg::ucode_t  cw;
  fbf_pkg::flags_t  flags;
  fbf_pkg::result_t res;
  fbf_pkg::result_t out_q;
  logic             fit_mode;
  logic             in_xfer;
  logic             out_busy;

  assign s_tready  = cw.op == fbf_pkg::OP_LATCH;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_busy  = m_tvalid && !m_tready;
  assign cfg_ready = 1'b1;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= 1'b0;
    end else if (cfg_valid) begin
      fit_mode <= cfg_data;
    end
  end

  fbf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .in_valid (s_tvalid),
    .out_busy (out_busy),
    .cw       (cw)
  );

  fbf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cw        (cw),
    .fit_mode  (fit_mode),
    .in_xfer   (in_xfer),
    .in_kind   (s_tuser),
    .in_start  (s_tdata[31:0]),
    .in_amount (s_tdata[63:32]),
    .flags     (flags),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cw.op == fbf_pkg::OP_EMIT && !out_busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == fbf_pkg::OP_EMIT && !out_busy) begin
      out_q <= res;
    end
  end

  assign m_tdata = {3'b000, out_q.leftover, out_q.grant_index, out_q.grant_address};
  assign m_tuser = out_q.status;

endmodule

@@ tb/tb_first_best_fit_hole_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_first_best_fit_hole_allocator
// Self-checking bench for the hole allocator. Items are fed on the input
// stream in bursts, and a local copy of the hole table works out each
// expected result when its item is accepted. Results are checked in order
// against that copy while the result side stalls on a rotating pattern.
// fit_mode is switched between phases, with the block quiet.
// ----------------------------------------------------------------------------
module tb_first_best_fit_hole_allocator;
  import fbf_pkg::*;

  localparam logic [1:0] KIND_SPARE  = 2'd3;       // unused kind, answered with an all-zero result
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         RAND_PHASES = 6;
  localparam int         PHASE_ITEMS = 175;

  typedef struct {
    logic [1:0]        kind;
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] amount;
    bit                drain_first;  // hold back until all grants are in
  } hole_item_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;  // [31:0] hole_start, [63:32] amount
  logic [1:0]  s_tuser   = '0;  // [1:0] kind
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;         // [31:0] grant_address, [36:32] grant_index,
                                // [68:37] leftover, [71:69] zero
  logic [1:0]  m_tuser;         // [1:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;

  // local copy of the hole table
  logic [DATA_W-1:0] tbl_addr  [MAX_HOLES];
  logic [DATA_W-1:0] tbl_len   [MAX_HOLES];
  bit                tbl_taken [MAX_HOLES];
  int                tbl_count = 0;
  bit                fit_best  = 1'b0;

  hole_item_t pending_items[$];
  result_t    grants_due[$];
  int         items_taken   = 0;
  int         grants_seen   = 0;
  int         mismatch_count = 0;
  int         cycle_count   = 0;

  hole_item_t accepted_item;
  int         burst_left = 0;
  int         gap_left   = 0;
  result_t    due;
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_left  = 0;

  first_best_fit_hole_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one item to the table copy and return the result it gives
  function automatic result_t predict_grant(hole_item_t it);
    result_t r;
    int      pick;
    r    = '0;
    pick = -1;
    case (it.kind)
      KIND_ADD: begin
        if (tbl_count >= MAX_HOLES) begin
          r.status = ST_FULL;
        end else begin
          tbl_addr[tbl_count]  = it.start;
          tbl_len[tbl_count]   = it.amount;
          tbl_taken[tbl_count] = 1'b0;
          r.grant_index        = IDX_W'(tbl_count);
          tbl_count++;
        end
      end
      KIND_REQ: begin
        // first fit stops at the first candidate; best fit keeps the
        // strictly smaller one, so ties go to the lower index
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_taken[i] && tbl_len[i] >= it.amount) begin
            if (pick < 0 || (fit_best && tbl_len[i] < tbl_len[pick])) pick = i;
          end
        end
        if (pick < 0) begin
          r.status = ST_NOFIT;
        end else begin
          tbl_taken[pick] = 1'b1;
          r.grant_address = tbl_addr[pick];
          r.grant_index   = IDX_W'(pick);
          // split off the remainder unless the table has no room for it
          if (tbl_len[pick] > it.amount && tbl_count < MAX_HOLES) begin
            r.leftover = tbl_len[pick] - it.amount;
            for (int i = tbl_count; i > pick + 1; i--) begin
              tbl_addr[i]  = tbl_addr[i-1];
              tbl_len[i]   = tbl_len[i-1];
              tbl_taken[i] = tbl_taken[i-1];
            end
            tbl_addr[pick+1]  = tbl_addr[pick] + it.amount;
            tbl_len[pick+1]   = r.leftover;
            tbl_taken[pick+1] = 1'b0;
            tbl_len[pick]     = it.amount;
            tbl_count++;
          end
        end
      end
      KIND_PASS: begin
        for (int i = 0; i < MAX_HOLES; i++) tbl_taken[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random item, request sizes drawn partly from the current table
  function automatic hole_item_t random_item();
    hole_item_t it;
    int         roll;
    int         slot;
    roll           = $urandom_range(0, 99);
    it.start       = $urandom;
    it.amount      = $urandom;
    it.drain_first = ($urandom_range(0, 59) == 0);
    if (roll < 12) begin
      it.kind = KIND_ADD;
      if ($urandom_range(0, 3) != 0) it.amount = $urandom_range(0, 2000);
    end else if (roll < 22) begin
      it.kind = KIND_PASS;
    end else if (roll < 25) begin
      it.kind = KIND_SPARE;
    end else begin
      it.kind = KIND_REQ;
      slot    = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
      roll    = $urandom_range(0, 99);
      if (tbl_count > 0 && roll < 40) begin
        it.amount = tbl_len[slot];
      end else if (tbl_count > 0 && roll < 65) begin
        it.amount = tbl_len[slot] - $urandom_range(1, 16);
      end else if (roll < 85) begin
        it.amount = $urandom_range(0, 300);
      end else if (roll < 90) begin
        it.amount = ($urandom_range(0, 1) == 0) ? '0 : '1;
      end
    end
    return it;
  endfunction

  task automatic queue_item(logic [1:0] kind, logic [DATA_W-1:0] start,
                            logic [DATA_W-1:0] amount, bit drain_first);
    hole_item_t it;
    it.kind        = kind;
    it.start       = start;
    it.amount      = amount;
    it.drain_first = drain_first;
    pending_items.push_back(it);
  endtask

  // Block until every queued item has been sent and answered
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || items_taken != grants_seen);
  endtask

  // fit_mode write on the config channel, block idle
  task automatic write_fit_mode(bit mode);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    fit_best   = mode;
    cfg_valid <= 1'b0;
  endtask

  // Sender: bursts of transfers with random gaps, valid held until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        accepted_item = pending_items.pop_front();
        grants_due.push_back(predict_grant(accepted_item));
        items_taken++;
        if (burst_left > 0) burst_left--;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first || items_taken == grants_seen)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {pending_items[0].amount, pending_items[0].start};
          s_tuser  <= pending_items[0].kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern rotated every cycle, reloaded now and then
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected result transfer, status %0d", m_tuser);
          mismatch_count++;
        end else begin
          due = grants_due.pop_front();
          grants_seen <= grants_seen + 1;
          if (m_tuser !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, m_tuser);
            mismatch_count++;
          end
          if (m_tdata[31:0] !== due.grant_address) begin
            $error("grant_address: expected %h, got %h", due.grant_address, m_tdata[31:0]);
            mismatch_count++;
          end
          if (m_tdata[36:32] !== due.grant_index) begin
            $error("grant_index: expected %0d, got %0d", due.grant_index, m_tdata[36:32]);
            mismatch_count++;
          end
          if (m_tdata[68:37] !== due.leftover) begin
            $error("leftover: expected %h, got %h", due.leftover, m_tdata[68:37]);
            mismatch_count++;
          end
        end
      end
      if (pat_left == 0) begin
        pat_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hFFFF;
          1:       stall_pat = 16'($urandom);
          2:       stall_pat = 16'($urandom & $urandom);
          default: stall_pat = 16'hFFFF ^ (16'h1 << $urandom_range(0, 15));
        endcase
        stall_pat |= 16'h1;
      end
      pat_left--;
      m_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first fit: empty table, wrap-around split, zero-size holes and requests
    queue_item(KIND_REQ,   32'h0000_1234, 32'd5,         1'b0);  // nothing fits
    queue_item(KIND_PASS,  32'h0,         32'h0,         1'b0);
    queue_item(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_item(KIND_ADD,   32'hFFFF_FFF0, 32'h40,        1'b0);
    queue_item(KIND_ADD,   32'h0,         32'h0,         1'b0);
    queue_item(KIND_ADD,   32'h1000,      32'hFFFF_FFFF, 1'b0);
    queue_item(KIND_ADD,   32'h2000,      32'h100,       1'b0);
    queue_item(KIND_REQ,   32'h0,         32'h20,        1'b0);  // remainder wraps
    queue_item(KIND_REQ,   32'h0,         32'h0,         1'b0);  // zero-size split
    queue_item(KIND_REQ,   32'h0,         32'hFFFF_FFFF, 1'b0);  // exact fit
    queue_item(KIND_REQ,   32'h0,         32'hFFFF_FFFF, 1'b0);  // now taken
    queue_item(KIND_PASS,  32'h0,         32'h0,         1'b0);
    wait_drained();

    // best fit: equal sizes, skipping taken holes, empty hole
    write_fit_mode(1'b1);
    @(negedge clk);
    queue_item(KIND_ADD,   32'h3000,      32'h100,       1'b0);
    queue_item(KIND_REQ,   32'h0,         32'h100,       1'b0);  // tie, lower index
    queue_item(KIND_REQ,   32'h0,         32'h80,        1'b1);  // skips taken hole
    queue_item(KIND_REQ,   32'h0,         32'h0,         1'b0);
    queue_item(KIND_REQ,   32'h0,         32'h10,        1'b0);
    wait_drained();

    // random phases, fit_mode alternating
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_fit_mode(p[0]);
      @(negedge clk);
      for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(random_item());
      pending_items[PHASE_ITEMS / 2].drain_first = 1'b1;
      wait_drained();
    end

    repeat (80) @(posedge clk);
    if (grants_due.size() != 0) begin
      $error("%0d results never arrived", grants_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/fbf_pkg.sv
rtl/core/fbf_ram.sv
rtl/core/fbf_seq.sv
rtl/core/fbf_dp.sv
rtl/core/first_best_fit_hole_allocator.sv
tb/tb_first_best_fit_hole_allocator.sv
